>>> rtl/tpps_pkg.sv
`default_nettype none

package tpps_pkg;

    // Field widths fixed by the interface.
    localparam int CLK_W    = 32;
    localparam int RATE_W   = 16;
    localparam int SEL_W    = 3;
    localparam int CMP_W    = 8;

    // The quotient is produced four bits per stage, so eight stages cover it.
    localparam int STEP_BITS  = 4;
    localparam int DIV_STAGES = CLK_W / STEP_BITS;

    typedef logic [CLK_W-1:0]  t_clk;
    typedef logic [RATE_W-1:0] t_rate;
    typedef logic [SEL_W-1:0]  t_sel;
    typedef logic [CMP_W-1:0]  t_cmp;

    // Clock select codes.
    localparam t_sel SEL_OFF     = 3'd0;
    localparam t_sel SEL_DIV1    = 3'd1;
    localparam t_sel SEL_DIV8    = 3'd2;
    localparam t_sel SEL_DIV64   = 3'd3;
    localparam t_sel SEL_DIV256  = 3'd4;
    localparam t_sel SEL_DIV1024 = 3'd5;
    localparam int   NUM_CODES   = 5;

    // Status codes.
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // Code for each prescaler tried, and the extra right shift taken before each try.
    localparam t_sel SEL_CODE [1:NUM_CODES] =
        '{SEL_DIV1, SEL_DIV8, SEL_DIV64, SEL_DIV256, SEL_DIV1024};
    localparam logic [3:0] STEP_SHIFT [0:NUM_CODES] = '{4'd0, 4'd0, 4'd3, 4'd3, 4'd2, 4'd2};

    localparam t_clk CLOCK_HZ_RESET = 32'd16000000;

    // One slot of the division pipeline: partial remainder, dividend bits still to
    // be consumed shifted together with the quotient bits produced, and the divisor.
    typedef struct packed {
        t_rate rem;
        t_clk  quo;
        t_rate divisor;
    } t_div;

endpackage

`default_nettype wire

>>> rtl/tpps_in_if.sv
`default_nettype none

interface tpps_in_if;
    import tpps_pkg::*;

    logic  valid;
    logic  ready;
    t_rate rate_hz;

    modport source (output valid, output rate_hz, input ready);
    modport sink   (input valid, input rate_hz, output ready);
endinterface

`default_nettype wire

>>> rtl/tpps_out_if.sv
`default_nettype none

interface tpps_out_if;
    import tpps_pkg::*;

    logic valid;
    logic ready;
    t_sel clock_select;
    t_cmp compare_value;
    logic status;

    modport source (output valid, output clock_select, output compare_value,
                    output status, input ready);
    modport sink   (input valid, input clock_select, input compare_value,
                    input status, output ready);
endinterface

`default_nettype wire

>>> rtl/timer_prescaler_period_select.sv
// Timer prescaler and compare value selection.
//
// Each input beat on i_in carries a requested tick rate in hertz. For every
// beat the block returns exactly one beat on o_out with the prescaler clock
// select code, the compare match value (scaled count minus one) and a status
// bit. A zero rate, a rate above the system clock, or a rate that no
// prescaler can reach comes back as clock select off, compare zero and a bad
// status. The system clock frequency is held in a single register written
// through i_cfg_wr_en / i_cfg_wr_data; write it only while no beat is in
// flight.
//
// An accepted beat passes through eight division stages, each producing four
// quotient bits, then one output stage that picks the prescaler, before it
// is offered. One beat is accepted per cycle unless every stage is full and
// the receiver stalls. Each stage holds its beat while the stage after it is
// full and stalled, so when the receiver stalls the pipeline compacts its
// bubbles and keeps taking input until every stage is occupied. Reset empties
// the pipeline and loads the clock register with 16 MHz.
`default_nettype none

module timer_prescaler_period_select #(
    parameter int COUNTER_RANGE = 256
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_wr_en,
    input  wire [tpps_pkg::CLK_W-1:0]    i_cfg_wr_data,
    tpps_in_if.sink                      i_in,
    tpps_out_if.source                   o_out
);
    import tpps_pkg::*;

    localparam int   NS       = DIV_STAGES;   // index of the output stage
    localparam t_clk LP_RANGE = CLK_W'(COUNTER_RANGE);

    // Four steps of restoring division. Each step shifts the next dividend bit
    // into the remainder and shifts the quotient bit in at the bottom.
    function automatic t_div div_steps(t_div a);
        t_div           b;
        logic [RATE_W:0] t;
        logic           ge;
        b = a;
        for (int i = 0; i < STEP_BITS; i++) begin
            t  = {b.rem, b.quo[CLK_W-1]};
            ge = (t >= {1'b0, b.divisor});
            if (ge) begin
                t = t - {1'b0, b.divisor};
            end
            b.rem = t[RATE_W-1:0];
            b.quo = {b.quo[CLK_W-2:0], ge};
        end
        return b;
    endfunction

    // Configuration register.
    t_clk r_clock_hz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= CLOCK_HZ_RESET;
        end else if (i_cfg_wr_en) begin
            r_clock_hz <= i_cfg_wr_data;
        end
    end

    // Stage valid bits and the ready chain. A stage may load when it is empty
    // or when its own beat moves on in the same cycle.
    logic [NS:0]   r_v;
    logic [NS+1:0] w_rdy;

    always_comb begin
        w_rdy[NS+1] = o_out.ready;
        for (int k = NS; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign i_in.ready = w_rdy[0];

    // Division stages.
    t_div r_div [0:NS-1];
    t_div n_div [0:NS-1];
    t_div w_load;

    always_comb begin
        w_load.rem     = '0;
        w_load.quo     = r_clock_hz;
        w_load.divisor = i_in.rate_hz;
        n_div[0]       = div_steps(w_load);
        for (int k = 1; k < NS; k++) begin
            n_div[k] = div_steps(r_div[k-1]);
        end
    end

    // Prescaler selection on the finished quotient.
    t_sel n_sel;
    t_cmp n_cmp;
    logic n_status;

    always_comb begin
        t_clk cnt;
        t_clk scaled;
        logic found;
        cnt    = r_div[NS-1].quo;
        scaled = '0;
        found  = 1'b0;
        n_sel  = SEL_OFF;
        for (int c = 1; c <= NUM_CODES; c++) begin
            cnt = cnt >> STEP_SHIFT[c];
            if (!found && (cnt <= LP_RANGE)) begin
                found  = 1'b1;
                n_sel  = SEL_CODE[c];
                scaled = cnt;
            end
        end
        // A zero divisor or a zero quotient (rate above the clock) is refused.
        if ((r_div[NS-1].divisor == '0) || (r_div[NS-1].quo == '0) || !found) begin
            n_sel    = SEL_OFF;
            n_cmp    = '0;
            n_status = STATUS_BAD;
        end else begin
            n_cmp    = (scaled == '0) ? '0 : CMP_W'(scaled - 1'b1);
            n_status = STATUS_OK;
        end
    end

    // Output register.
    t_sel r_out_sel;
    t_cmp r_out_cmp;
    logic r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k <= NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (w_rdy[k]) begin
                r_div[k] <= n_div[k];
            end
        end
        if (w_rdy[NS]) begin
            r_out_sel    <= n_sel;
            r_out_cmp    <= n_cmp;
            r_out_status <= n_status;
        end
    end

    assign o_out.valid         = r_v[NS];
    assign o_out.clock_select  = r_out_sel;
    assign o_out.compare_value = r_out_cmp;
    assign o_out.status        = r_out_status;

`ifndef SYNTH
    // A refused request always reports the timer switched off with a zero compare.
    a_bad_is_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS] && (r_out_status == STATUS_BAD)) |->
            ((r_out_sel == SEL_OFF) && (r_out_cmp == '0)))
        else $error("bad status without clock select off");

    // An accepted request always names a running prescaler.
    a_ok_is_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS] && (r_out_status == STATUS_OK)) |-> (r_out_sel != SEL_OFF))
        else $error("ok status with clock select off");

    // A full last division stage that cannot move keeps its beat.
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS-1] && !w_rdy[NS]) |=> r_v[NS-1])
        else $error("stalled division stage lost its beat");

    // An output beat only appears when the last division stage held one.
    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v[NS]) |-> $past(r_v[NS-1]))
        else $error("output beat appeared from an empty stage");
`endif

endmodule

`default_nettype wire
